@@ rtl/mbsp_pkg.sv @@
// Shared types and constants for the MIDI byte stream parser.
// No dependencies; every other file of the block but mbsp_if.sv imports this package.
package mbsp_pkg;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_SYSEX  = 2'd3;

  localparam logic [2:0] EV_STATUS_ONLY = 3'd0;
  localparam logic [2:0] EV_ONE_DATA    = 3'd1;
  localparam logic [2:0] EV_TWO_DATA    = 3'd2;
  localparam logic [2:0] EV_SYSEX_OPEN  = 3'd3;
  localparam logic [2:0] EV_SYSEX_BYTE  = 3'd4;
  localparam logic [2:0] EV_SYSEX_CLOSE = 3'd5;

  localparam logic [7:0] ST_CHAN_LOW  = 8'h80;
  localparam logic [7:0] ST_CHAN_MID  = 8'hc0;
  localparam logic [7:0] ST_CHAN_HIGH = 8'he0;
  localparam logic [7:0] ST_SYSEX     = 8'hf0;
  localparam logic [7:0] ST_MTC_QF    = 8'hf1;
  localparam logic [7:0] ST_SONG_POS  = 8'hf2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hf3;
  localparam logic [7:0] ST_EOX       = 8'hf7;

  typedef struct packed {
    logic [7:0] running_status;
    logic [1:0] parse_phase;
    logic [7:0] held_data;
  } parse_state_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [7:0] second_data;
  } midi_event_t;

  // Channel messages 80-BF and E0-EF carry two data bytes.
  function automatic logic chan_two(input logic [7:0] s);
    chan_two = (s >= ST_CHAN_LOW && s < ST_CHAN_MID) ||
               (s >= ST_CHAN_HIGH && s < ST_SYSEX);
  endfunction

endpackage

@@ rtl/mbsp_if.sv @@
// Handshake channel interfaces for the MIDI byte stream parser.
// Depends on mbsp_pkg for nothing but shares its naming; one byte channel, one event channel.
interface mbsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbsp_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] status_byte;
  logic [7:0] first_data;
  logic [7:0] second_data;

  modport source (output valid, output event_kind, output status_byte,
                  output first_data, output second_data, input ready);
  modport sink   (input valid, input event_kind, input status_byte,
                  input first_data, input second_data, output ready);
endinterface

@@ rtl/mbsp_step.sv @@
// Parse rule for one received byte: next parser state and the event it yields.
// Depends on mbsp_pkg for the state and event types and the status codes.
module mbsp_step
  import mbsp_pkg::*;
(
  input  parse_state_t cur,
  input  logic [7:0]   rx_byte,
  output parse_state_t nxt,
  output logic         res_valid,
  output midi_event_t  res
);

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    case (cur.parse_phase)
      PH_FIRST: begin
        if (chan_two(cur.running_status) || cur.running_status == ST_SONG_POS) begin
          nxt.held_data   = rx_byte;
          nxt.parse_phase = PH_SECOND;
        end else begin
          nxt.parse_phase = PH_IDLE;
          res_valid       = 1'b1;
          res.event_kind  = EV_ONE_DATA;
          res.status_byte = cur.running_status;
          res.first_data  = rx_byte;
        end
      end
      PH_SECOND: begin
        nxt.parse_phase = PH_IDLE;
        res_valid       = 1'b1;
        res.event_kind  = EV_TWO_DATA;
        res.status_byte = cur.running_status;
        res.first_data  = cur.held_data;
        res.second_data = rx_byte;
      end
      PH_SYSEX: begin
        res_valid = 1'b1;
        if (rx_byte == ST_EOX) begin
          nxt.parse_phase = PH_IDLE;
          res.event_kind  = EV_SYSEX_CLOSE;
          res.status_byte = ST_EOX;
        end else begin
          res.event_kind  = EV_SYSEX_BYTE;
          res.status_byte = ST_SYSEX;
          res.first_data  = rx_byte;
        end
      end
      default: begin
        if (!rx_byte[7]) begin
          // A data byte outside a message reuses the running status.
          if (chan_two(cur.running_status)) begin
            nxt.held_data   = rx_byte;
            nxt.parse_phase = PH_SECOND;
          end else begin
            res_valid       = 1'b1;
            res.event_kind  = EV_ONE_DATA;
            res.status_byte = cur.running_status;
            res.first_data  = rx_byte;
          end
        end else begin
          nxt.running_status = rx_byte;
          if (rx_byte < ST_SYSEX || rx_byte == ST_MTC_QF || rx_byte == ST_SONG_POS ||
              rx_byte == ST_SONG_SEL) begin
            nxt.parse_phase = PH_FIRST;
          end else if (rx_byte == ST_SYSEX) begin
            nxt.parse_phase = PH_SYSEX;
            res_valid       = 1'b1;
            res.event_kind  = EV_SYSEX_OPEN;
            res.status_byte = ST_SYSEX;
          end else begin
            res_valid       = 1'b1;
            res.event_kind  = EV_STATUS_ONLY;
            res.status_byte = rx_byte;
          end
        end
      end
    endcase
  end

endmodule

@@ rtl/midi_byte_stream_parser_top.sv @@
// Top level of the MIDI byte stream parser: parser state, output register, checks.
// Depends on mbsp_pkg, mbsp_if.sv (channel interfaces) and mbsp_step.
//
//   channel | direction | payload
//   rx      | sink      | rx_byte (8 bits)
//   evt     | source    | event_kind (3), status_byte, first_data, second_data (8 each)
//
// One byte is taken per cycle; its event, if any, appears on evt the next cycle.
// The single output register sets the rate: rx is ready whenever that register is
// empty or is being emptied in the same cycle, so a stall on evt stops rx at once.
// Synchronous reset clears the running status, the phase, the held byte and evt.valid.
module midi_byte_stream_parser_top
  import mbsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  mbsp_byte_if.sink    rx,
  mbsp_event_if.source evt
);

  parse_state_t state;
  parse_state_t state_next;
  logic         res_valid;
  midi_event_t  res;
  logic         out_valid;
  midi_event_t  out_event;
  logic         rx_xfer;

  mbsp_step u_step (
    .cur       (state),
    .rx_byte   (rx.rx_byte),
    .nxt       (state_next),
    .res_valid (res_valid),
    .res       (res)
  );

  assign rx.ready = !out_valid || evt.ready;
  assign rx_xfer  = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (rx_xfer) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_xfer) begin
      out_valid <= res_valid;
    end else if (evt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_xfer && res_valid) begin
      out_event <= res;
    end
  end

  assign evt.valid       = out_valid;
  assign evt.event_kind  = out_event.event_kind;
  assign evt.status_byte = out_event.status_byte;
  assign evt.first_data  = out_event.first_data;
  assign evt.second_data = out_event.second_data;

  // Awaiting a second data byte only under a status that takes two.
  a_second_status: assert property (@(posedge clk) disable iff (rst)
    state.parse_phase == PH_SECOND |->
      (chan_two(state.running_status) || state.running_status == ST_SONG_POS))
    else $error("second-data phase under a one-data running status");

  // Inside system exclusive the running status stays F0.
  a_sysex_status: assert property (@(posedge clk) disable iff (rst)
    state.parse_phase == PH_SYSEX |-> state.running_status == ST_SYSEX)
    else $error("sysex phase without F0 running status");

  // The first-data phase follows only a status that takes data.
  a_first_status: assert property (@(posedge clk) disable iff (rst)
    state.parse_phase == PH_FIRST |->
      (state.running_status[7] && (state.running_status < ST_SYSEX ||
       state.running_status == ST_MTC_QF || state.running_status == ST_SONG_POS ||
       state.running_status == ST_SONG_SEL)))
    else $error("first-data phase under a status that takes no data");

  // A byte taken while awaiting second data always completes a two-data event.
  a_two_data_out: assert property (@(posedge clk) disable iff (rst)
    (rx_xfer && state.parse_phase == PH_SECOND) |=>
      (evt.valid && evt.event_kind == EV_TWO_DATA))
    else $error("second data byte did not produce a two-data event");

endmodule

@@ tb/midi_byte_stream_parser_top_tb.sv @@
// Self-checking testbench for midi_byte_stream_parser_top: MIDI bytes in, framed events out.
// Depends on mbsp_pkg, the channel interfaces in mbsp_if.sv and the parser RTL.
module midi_byte_stream_parser_top_tb;
  import mbsp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_BYTES = 1020;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mbsp_byte_if  rx_ch ();
  mbsp_event_if evt_ch ();

  midi_byte_stream_parser_top DUT (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .evt (evt_ch)
  );

  // Byte stream waiting to be sent, and events the framer is predicted to produce.
  logic [7:0]  stim_q [$];
  midi_event_t expected_events [$];

  // Predicted framer state.
  logic [7:0] run_status = 8'h00;
  logic [1:0] phase      = PH_IDLE;
  logic [7:0] held       = 8'h00;

  midi_event_t framed;
  midi_event_t want;
  int          total_bytes    = 0;
  int          bytes_taken    = 0;
  int          events_checked = 0;
  int          sysex_payloads = 0;
  int          error_count    = 0;
  int          cycle_count    = 0;
  int          hold_left      = 0;
  bit          hold_done      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Channel voice messages 80-BF and E0-EF carry two data bytes.
  function automatic bit takes_two(input logic [7:0] s);
    takes_two = (s[7:6] == 2'b10) || (s[7:4] == 4'he);
  endfunction

  // Frames one received byte; returns 1 when the byte completes an event.
  function automatic bit frame_byte(input logic [7:0] b, output midi_event_t ev);
    ev = '0;
    frame_byte = 1'b0;
    case (phase)
      PH_FIRST: begin
        if (takes_two(run_status) || run_status == ST_SONG_POS) begin
          held  = b;
          phase = PH_SECOND;
        end else begin
          phase      = PH_IDLE;
          ev         = {EV_ONE_DATA, run_status, b, 8'h00};
          frame_byte = 1'b1;
        end
      end
      PH_SECOND: begin
        phase      = PH_IDLE;
        ev         = {EV_TWO_DATA, run_status, held, b};
        frame_byte = 1'b1;
      end
      PH_SYSEX: begin
        frame_byte = 1'b1;
        if (b == ST_EOX) begin
          phase = PH_IDLE;
          ev    = {EV_SYSEX_CLOSE, ST_EOX, 8'h00, 8'h00};
        end else begin
          ev = {EV_SYSEX_BYTE, ST_SYSEX, b, 8'h00};
        end
      end
      default: begin
        if (!b[7]) begin
          // A data byte outside a message starts one under the running status.
          if (takes_two(run_status)) begin
            held  = b;
            phase = PH_SECOND;
          end else begin
            ev         = {EV_ONE_DATA, run_status, b, 8'h00};
            frame_byte = 1'b1;
          end
        end else begin
          run_status = b;
          if (b < ST_SYSEX || b == ST_MTC_QF || b == ST_SONG_POS || b == ST_SONG_SEL) begin
            phase = PH_FIRST;
          end else if (b == ST_SYSEX) begin
            phase      = PH_SYSEX;
            ev         = {EV_SYSEX_OPEN, ST_SYSEX, 8'h00, 8'h00};
            frame_byte = 1'b1;
          end else begin
            ev         = {EV_STATUS_ONLY, b, 8'h00, 8'h00};
            frame_byte = 1'b1;
          end
        end
      end
    endcase
  endfunction

  // Idle percentage for either side: first the receiver is the slow one, then the
  // sender, and in the last third neither side idles.
  function automatic int gap_pct(input bit receiver);
    if (bytes_taken * 3 < total_bytes) begin
      gap_pct = receiver ? 74 : 35;
    end else if (bytes_taken * 3 < total_bytes * 2) begin
      gap_pct = receiver ? 35 : 74;
    end else begin
      gap_pct = 0;
    end
  endfunction

  // Mostly well-formed messages with random content, plus stray and broken sequences.
  task automatic add_random_stream(input int count);
    int         target;
    int         pick;
    logic [7:0] st;
    logic [7:0] b;
    target = stim_q.size() + count;
    while (stim_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        st[7]   = 1'b1;
        st[6:4] = 3'($urandom_range(0, 6));
        st[3:0] = 4'($urandom_range(0, 15));
        stim_q.push_back(st);
        repeat ($urandom_range(1, 3)) begin
          stim_q.push_back(8'($urandom_range(0, 127)));
          if (takes_two(st)) stim_q.push_back(8'($urandom_range(0, 127)));
        end
      end else if (pick < 50) begin
        repeat ($urandom_range(1, 2)) stim_q.push_back(8'($urandom_range(0, 127)));
      end else if (pick < 62) begin
        st = ST_MTC_QF + 8'($urandom_range(0, 5));
        stim_q.push_back(st);
        if (st == ST_SONG_POS) begin
          stim_q.push_back(8'($urandom_range(0, 127)));
          stim_q.push_back(8'($urandom_range(0, 127)));
        end else if (st <= ST_SONG_SEL) begin
          stim_q.push_back(8'($urandom_range(0, 127)));
        end
      end else if (pick < 76) begin
        stim_q.push_back(ST_SYSEX);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 9) == 0) begin
            b = 8'($urandom_range(0, 255));
            if (b == ST_EOX) b = ST_SYSEX;
          end else begin
            b = 8'($urandom_range(0, 127));
          end
          stim_q.push_back(b);
        end
        // Now and then the closing byte is missing and the next bytes become payload.
        if ($urandom_range(0, 9) != 0) stim_q.push_back(ST_EOX);
      end else if (pick < 86) begin
        stim_q.push_back(8'($urandom_range(8'hf7, 8'hff)));
      end else if (pick < 93) begin
        // Status bytes inside a message are taken as data.
        st = 8'($urandom_range(8'h80, 8'hef));
        stim_q.push_back(st);
        stim_q.push_back(8'($urandom_range(0, 255)));
        if (takes_two(st)) stim_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        stim_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Sender: predicts on each transfer, then offers the next byte unless idling.
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid   <= 1'b0;
      rx_ch.rx_byte <= 8'h00;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        if (frame_byte(rx_ch.rx_byte, framed)) expected_events.push_back(framed);
        bytes_taken <= bytes_taken + 1;
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if (stim_q.size() != 0 &&
            (hold_left != 0 || $urandom_range(0, 99) >= gap_pct(1'b0))) begin
          rx_ch.valid   <= 1'b1;
          rx_ch.rx_byte <= stim_q.pop_front();
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each event transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      evt_ch.ready <= 1'b0;
    end else begin
      if (evt_ch.valid && evt_ch.ready) begin
        if (expected_events.size() == 0) begin
          error_count++;
          $display("%0t: expected no event, got kind %0d status %h data %h %h", $time,
                   evt_ch.event_kind, evt_ch.status_byte, evt_ch.first_data,
                   evt_ch.second_data);
        end else begin
          want = expected_events.pop_front();
          events_checked++;
          if (want.event_kind == EV_SYSEX_BYTE) sysex_payloads++;
          if (evt_ch.event_kind !== want.event_kind) begin
            error_count++;
            $display("%0t: event_kind expected %0d actual %0d", $time,
                     want.event_kind, evt_ch.event_kind);
          end
          if (evt_ch.status_byte !== want.status_byte) begin
            error_count++;
            $display("%0t: status_byte expected %h actual %h", $time,
                     want.status_byte, evt_ch.status_byte);
          end
          if (evt_ch.first_data !== want.first_data) begin
            error_count++;
            $display("%0t: first_data expected %h actual %h", $time,
                     want.first_data, evt_ch.first_data);
          end
          if (evt_ch.second_data !== want.second_data) begin
            error_count++;
            $display("%0t: second_data expected %h actual %h", $time,
                     want.second_data, evt_ch.second_data);
          end
        end
      end
      evt_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= gap_pct(1'b1));
    end
  end

  // One long hold-off on the event channel half way through, so that the output
  // register fills and the byte channel stalls.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken * 2 >= total_bytes) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int drain;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    evt_ch.ready  = 1'b0;
    stim_q = '{
      8'h00, 8'h7f,                       // data before any status byte
      8'h90, 8'h3c, 8'h7f, 8'h40, 8'h00,  // note on, then running status
      8'hc5, 8'h05, 8'h12,                // program change, then running status
      8'hf2, 8'h01, 8'h02, 8'h03,         // song position, then data under F2
      8'hf1, 8'h10, 8'hf3, 8'h7f,
      8'hf0, 8'h01, 8'h90, 8'hff, 8'hf7,  // sysex carrying status bytes
      8'h22,                              // data under running status F0
      8'hff, 8'hf7, 8'hf4,                // real-time, lone EOX, undefined
      8'hb0, 8'he0, 8'hff                 // status bytes taken as data
    };
    add_random_stream(RANDOM_BYTES);
    total_bytes = stim_q.size();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || rx_ch.valid) @(negedge clk);
    drain = 0;
    while (expected_events.size() != 0 && drain < 4000) begin
      @(negedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_events.size() != 0) begin
      error_count++;
      $display("%0t: %0d events never arrived, first expected kind %0d status %h, actual none",
               $time, expected_events.size(), expected_events[0].event_kind,
               expected_events[0].status_byte);
    end

    $display("Sent %0d MIDI bytes and checked %0d framed events (%0d sysex payload bytes),",
             bytes_taken, events_checked, sysex_payloads);
    $display("under three idle mixes and one %0d-cycle hold-off on the event channel.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
